// ===== hdl/psu_pkg.sv =====
// Package for the PNG scanline unfilter: field widths, parameter defaults,
// filter type codes and configuration register indexes.
// No dependencies.
`timescale 1ns / 1ps

package psu_pkg;

    localparam int MAX_ROW_BYTES_DEF   = 4096;
    localparam int MAX_PIXEL_BYTES_DEF = 4;

    localparam int BYTE_W  = 8;
    localparam int BPP_W   = 3;
    localparam int LEN_W   = 13;
    localparam int ROWS_W  = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4,
        FILT_BAD   = 3'd5
    } filt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BYTES_PER_PIXEL = 2'd0,
        CFG_ROW_DATA_BYTES  = 2'd1,
        CFG_IMAGE_ROWS      = 2'd2
    } cfg_idx_t;

endpackage

// ===== hdl/psu_if.sv =====
// Stream interfaces of the PNG scanline unfilter: the filtered input byte
// channel and the reconstructed output channel. Depends on psu_pkg.
`timescale 1ns / 1ps

interface psu_in_if;
    logic                      valid;
    logic                      ready;
    logic [psu_pkg::BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface psu_out_if;
    logic                      valid;
    logic                      ready;
    logic [psu_pkg::BYTE_W-1:0] out_byte;
    logic                      is_type_byte;
    logic                      row_end;
    logic                      image_end;
    logic                      bad_type;

    modport source (output valid, output out_byte, output is_type_byte, output row_end,
                    output image_end, output bad_type, input ready);
    modport sink   (input valid, input out_byte, input is_type_byte, input row_end,
                    input image_end, input bad_type, output ready);
endinterface

// ===== hdl/png_scanline_unfilter.sv =====
// A result beat is registered and valid in the cycle after its input beat is accepted.
// Throughput: one byte per cycle unless the output is stalled by back-pressure; the limit
// is the path from the left-neighbor history through the Paeth predictor into the output
// register, with the line store read one byte ahead on its single read port.
// Reset: configuration registers return to 1, position and row count to zero; the line store
// is not cleared and the first row after reset reads zeros from above.

// PNG scanline filter reconstruction top level with its line store.
// Depends on psu_pkg and the interfaces in psu_if.
`timescale 1ns / 1ps

module png_scanline_unfilter #(
    parameter int MAX_ROW_BYTES   = psu_pkg::MAX_ROW_BYTES_DEF,
    parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    psu_in_if.sink                        in_ch,
    psu_out_if.source                     out_ch,
    input  logic                          cfg_we,
    input  logic [psu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [psu_pkg::CFG_W-1:0]     cfg_data
);

    localparam int AW  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int IW  = (AW > psu_pkg::LEN_W) ? AW : psu_pkg::LEN_W;
    localparam int MW  = $clog2(MAX_ROW_BYTES + 1);
    localparam int CW  = (MW > psu_pkg::LEN_W) ? MW : psu_pkg::LEN_W;
    localparam int PIW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int BW  = 4;

    // Configuration registers.
    logic [psu_pkg::BPP_W-1:0]  bpp_reg;
    logic [psu_pkg::LEN_W-1:0]  len_reg;
    logic [psu_pkg::ROWS_W-1:0] rows_reg;

    // Row state.
    psu_pkg::filt_t             row_type_reg;
    logic [psu_pkg::LEN_W-1:0]  pos_reg;
    logic [psu_pkg::ROWS_W-1:0] row_cnt_reg;
    logic [7:0]                 left_reg  [MAX_PIXEL_BYTES];
    logic [7:0]                 upleft_reg [MAX_PIXEL_BYTES];

    // Line store with registered read data.
    logic [7:0]    mem [MAX_ROW_BYTES];
    logic [7:0]    above_reg;

    // Output register.
    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          out_type_reg;
    logic          out_row_end_reg;
    logic          out_img_end_reg;
    logic          out_bad_reg;

    logic                  in_fire;
    logic                  is_type;
    logic [BW-1:0]         bpp_eff;
    logic [PIW-1:0]        hist_sel;
    logic [CW-1:0]         len_eff;
    logic [psu_pkg::ROWS_W-1:0] rows_eff;
    logic [IW-1:0]         idx_w;
    logic [AW-1:0]         idx;
    logic                  row_done;
    logic                  last_row;
    logic [7:0]            a_val;
    logic [7:0]            b_val;
    logic [7:0]            c_val;
    logic [7:0]            pred;
    logic [7:0]            recon;
    logic [8:0]            avg_sum;
    logic signed [9:0]     d_pa;
    logic signed [9:0]     d_pb;
    logic signed [9:0]     d_pc;
    logic [9:0]            abs_pa;
    logic [9:0]            abs_pb;
    logic [9:0]            abs_pc;
    logic [7:0]            paeth_val;
    psu_pkg::filt_t        new_type;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign is_type     = (pos_reg == '0);

    // Effective register values after clamping.
    always_comb
    begin
        bpp_eff = {1'b0, bpp_reg};
        if (bpp_eff == '0)
            bpp_eff = BW'(1);
        else if (bpp_eff > BW'(MAX_PIXEL_BYTES))
            bpp_eff = BW'(MAX_PIXEL_BYTES);

        len_eff = CW'(len_reg);
        if (len_eff == '0)
            len_eff = CW'(1);
        else if (len_eff > CW'(MAX_ROW_BYTES))
            len_eff = CW'(MAX_ROW_BYTES);

        rows_eff = (rows_reg == '0) ? psu_pkg::ROWS_W'(1) : rows_reg;
    end

    assign hist_sel = PIW'(bpp_eff - BW'(1));
    assign idx_w    = IW'(pos_reg) - IW'(1);
    assign idx      = idx_w[AW-1:0];
    assign row_done = (CW'(pos_reg) >= len_eff);
    assign last_row = ({1'b0, row_cnt_reg} + 17'd1) >= {1'b0, rows_eff};

    assign a_val = left_reg[hist_sel];
    assign b_val = (row_cnt_reg != '0) ? above_reg : 8'd0;
    assign c_val = (row_cnt_reg != '0) ? upleft_reg[hist_sel] : 8'd0;

    // Paeth: with p = a + b - c, the distances are |b - c|, |a - c|, |a + b - 2c|.
    always_comb
    begin
        d_pa = $signed({2'b00, b_val}) - $signed({2'b00, c_val});
        d_pb = $signed({2'b00, a_val}) - $signed({2'b00, c_val});
        d_pc = d_pa + d_pb;
        abs_pa = (d_pa < 0) ? 10'(-d_pa) : 10'(d_pa);
        abs_pb = (d_pb < 0) ? 10'(-d_pb) : 10'(d_pb);
        abs_pc = (d_pc < 0) ? 10'(-d_pc) : 10'(d_pc);
        if (abs_pa <= abs_pb && abs_pa <= abs_pc)
            paeth_val = a_val;
        else if (abs_pb <= abs_pc)
            paeth_val = b_val;
        else
            paeth_val = c_val;
    end

    always_comb
    begin
        avg_sum = {1'b0, a_val} + {1'b0, b_val};
        unique case (row_type_reg)
            psu_pkg::FILT_SUB:   pred = a_val;
            psu_pkg::FILT_UP:    pred = b_val;
            psu_pkg::FILT_AVG:   pred = avg_sum[8:1];
            psu_pkg::FILT_PAETH: pred = paeth_val;
            default:             pred = 8'd0;
        endcase
        recon = in_ch.in_byte + pred;
    end

    assign new_type = (in_ch.in_byte > 8'd4) ? psu_pkg::FILT_BAD
                                             : psu_pkg::filt_t'(in_ch.in_byte[2:0]);

    // The byte above is fetched one beat ahead: on the type beat for column zero,
    // on each data beat for the next column.
    assign rd_en   = in_fire && (is_type || !row_done);
    assign rd_addr = is_type ? '0 : idx + AW'(1);

    always_ff @(posedge clk)
    begin
        if (in_fire && !is_type)
            mem[idx] <= recon;
        if (rd_en)
            above_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg  <= psu_pkg::BPP_W'(1);
            len_reg  <= psu_pkg::LEN_W'(1);
            rows_reg <= psu_pkg::ROWS_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                psu_pkg::CFG_BYTES_PER_PIXEL: bpp_reg  <= cfg_data[psu_pkg::BPP_W-1:0];
                psu_pkg::CFG_ROW_DATA_BYTES:  len_reg  <= cfg_data[psu_pkg::LEN_W-1:0];
                psu_pkg::CFG_IMAGE_ROWS:      rows_reg <= cfg_data[psu_pkg::ROWS_W-1:0];
                default:                      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_type_reg <= psu_pkg::FILT_NONE;
            pos_reg      <= '0;
            row_cnt_reg  <= '0;
            for (int k = 0; k < MAX_PIXEL_BYTES; k++)
            begin
                left_reg[k]   <= 8'd0;
                upleft_reg[k] <= 8'd0;
            end
        end
        else if (in_fire)
        begin
            if (is_type)
            begin
                row_type_reg <= new_type;
                pos_reg      <= psu_pkg::LEN_W'(1);
                for (int k = 0; k < MAX_PIXEL_BYTES; k++)
                begin
                    left_reg[k]   <= 8'd0;
                    upleft_reg[k] <= 8'd0;
                end
            end
            else
            begin
                for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--)
                begin
                    left_reg[k]   <= left_reg[k-1];
                    upleft_reg[k] <= upleft_reg[k-1];
                end
                left_reg[0]   <= recon;
                upleft_reg[0] <= b_val;
                if (row_done)
                begin
                    pos_reg     <= '0;
                    row_cnt_reg <= last_row ? '0 : row_cnt_reg + psu_pkg::ROWS_W'(1);
                end
                else
                begin
                    pos_reg <= pos_reg + psu_pkg::LEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ch.ready)
            out_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_byte_reg    <= is_type ? in_ch.in_byte : recon;
            out_type_reg    <= is_type;
            out_row_end_reg <= !is_type && row_done;
            out_img_end_reg <= !is_type && row_done && last_row;
            out_bad_reg     <= is_type ? (new_type == psu_pkg::FILT_BAD)
                                       : (row_type_reg == psu_pkg::FILT_BAD);
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.out_byte     = out_byte_reg;
    assign out_ch.is_type_byte = out_type_reg;
    assign out_ch.row_end      = out_row_end_reg;
    assign out_ch.image_end    = out_img_end_reg;
    assign out_ch.bad_type     = out_bad_reg;

    // A type beat never closes a row or an image.
    a_type_not_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_type_reg |-> !out_row_end_reg && !out_img_end_reg)
        else $error("type beat flagged as row or image end");

    // The image only ends where a row ends.
    a_img_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_img_end_reg |-> out_row_end_reg)
        else $error("image end without row end");

    // The byte position never passes the line store depth.
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(pos_reg) <= CW'(MAX_ROW_BYTES))
        else $error("byte position beyond line store");

    // An accepted type beat moves the row to its first data column.
    a_type_step: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n && in_fire && is_type) |-> pos_reg == psu_pkg::LEN_W'(1))
        else $error("type beat did not start the row");

    // A row end beat returns the position to the type byte.
    a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n && in_fire && !is_type && row_done) |-> pos_reg == '0)
        else $error("row end did not return to type byte");

endmodule
